// File: rtl/csq_pkg.sv
`timescale 1ns / 1ps

package csq_pkg;

  // Field widths fixed by the interface.
  localparam int CNT_W  = 16;
  localparam int ID_W   = 8;
  localparam int PRIO_W = 8;

  // Operation codes carried on the input channel.
  typedef enum logic [1:0] {
    OP_TAKE_WAIT   = 2'd0,
    OP_TAKE_NOWAIT = 2'd1,
    OP_RELEASE     = 2'd2,
    OP_RESET       = 2'd3
  } op_t;

  // Result status codes.
  typedef enum logic [3:0] {
    ST_GRANTED    = 4'd0,
    ST_UNAVAIL    = 4'd1,
    ST_QUEUED     = 4'd2,
    ST_RAISED     = 4'd3,
    ST_WOKEN      = 4'd4,
    ST_FULL       = 4'd5,
    ST_QFULL      = 4'd6,
    ST_RESET_WAKE = 4'd7,
    ST_RESET_DONE = 4'd8
  } status_t;

  // Controller states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_INSERT
  } state_t;

  // Entry traveling down the chain during an insert.
  typedef struct packed {
    logic              vld;
    logic              disp;
    logic [ID_W-1:0]   id;
    logic [PRIO_W-1:0] prio;
  } carry_t;

  // Control shared by all cells.
  typedef struct packed {
    logic pop;
    logic mode;
  } cell_ctrl_t;

endpackage

// File: rtl/counting_semaphore_wait_queue_unit.sv
`timescale 1ns / 1ps
// The input is ready only in S_IDLE, where an accepted transaction is latched. Its result
// is loaded into the output register from S_EXEC once that register is free. A queued take
// with waiters already in the queue then stays in S_INSERT while the insert carry moves one
// cell per cycle to the first free cell. A reset with waiters gives one wake result per cycle
// while the output is not stalled, then a last result. Back-pressure holds S_EXEC.
// Reset (rst_n, synchronous): count, queue fill, ordering mode and handshakes clear;
// waiter entries hold no value until written.

module counting_semaphore_wait_queue_unit
  import csq_pkg::*;
#(
  parameter int QUEUE_DEPTH = 16,
  parameter int COUNT_MAX   = 65535
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: ordering mode, 0 first-in first-out, 1 by priority.
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,
  // Input channel.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // thread_id [7:0], priority_req [15:8], new_count [31:16]
  input  logic [1:0]  in_tuser,   // op [1:0]
  // Result channel.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // who [7:0], count_now [23:8]
  output logic [3:0]  out_tuser,  // status [3:0]
  output logic        out_tlast   // last
);

  localparam int TW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [CNT_W-1:0] CMAX = CNT_W'(COUNT_MAX);
  localparam logic [TW-1:0]    QFULL_N = TW'(QUEUE_DEPTH);

  state_t            state_r, state_nxt;
  op_t               op_r, op_nxt;
  logic [ID_W-1:0]   tid_r, tid_nxt;
  logic [PRIO_W-1:0] rprio_r, rprio_nxt;
  logic [CNT_W-1:0]  nc_r, nc_nxt;
  logic [CNT_W-1:0]  count_r, count_nxt;
  logic [TW-1:0]     total_r, total_nxt;
  logic [TW-1:0]     walk_r, walk_nxt;
  logic              mode_r;

  logic              out_valid_r;
  status_t           out_status_r;
  logic [ID_W-1:0]   out_who_r;
  logic [CNT_W-1:0]  out_count_r;
  logic              out_last_r;

  logic              out_free;
  logic              out_load;
  status_t           res_status;
  logic [ID_W-1:0]   res_who;
  logic              res_last;

  cell_ctrl_t        cctrl;
  carry_t            launch;
  carry_t            chain_c [QUEUE_DEPTH+1];
  logic [ID_W-1:0]   cell_id [QUEUE_DEPTH];
  logic [PRIO_W-1:0] cell_prio [QUEUE_DEPTH];

  // Row of queue cells; cell 0 is the head.
  assign chain_c[0] = launch;

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    logic [ID_W-1:0]   nb_id;
    logic [PRIO_W-1:0] nb_prio;
    if (i + 1 < QUEUE_DEPTH) begin : g_nb
      assign nb_id   = cell_id[i+1];
      assign nb_prio = cell_prio[i+1];
    end else begin : g_tail
      assign nb_id   = '0;
      assign nb_prio = '0;
    end
    csq_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cctrl),
      .occ     (total_r > TW'(i)),
      .cin     (chain_c[i]),
      .cout    (chain_c[i+1]),
      .nb_id   (nb_id),
      .nb_prio (nb_prio),
      .id_o    (cell_id[i]),
      .prio_o  (cell_prio[i])
    );
  end

  assign out_free = !out_valid_r || out_tready;

  // Operation sequencer.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    tid_nxt    = tid_r;
    rprio_nxt  = rprio_r;
    nc_nxt     = nc_r;
    count_nxt  = count_r;
    total_nxt  = total_r;
    walk_nxt   = walk_r;
    in_tready  = 1'b0;
    cctrl.pop  = 1'b0;
    cctrl.mode = mode_r;
    launch     = '0;
    out_load   = 1'b0;
    res_status = ST_GRANTED;
    res_who    = tid_r;
    res_last   = 1'b1;
    case (state_r)
      S_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          op_nxt    = op_t'(in_tuser);
          tid_nxt   = in_tdata[7:0];
          rprio_nxt = in_tdata[15:8];
          nc_nxt    = in_tdata[31:16];
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = S_IDLE;
          case (op_r)
            OP_TAKE_WAIT, OP_TAKE_NOWAIT: begin
              if (count_r != '0) begin
                count_nxt  = count_r - 1'b1;
                res_status = ST_GRANTED;
              end else if (op_r == OP_TAKE_NOWAIT) begin
                res_status = ST_UNAVAIL;
              end else if (total_r == QFULL_N) begin
                res_status = ST_QFULL;
              end else begin
                launch.vld  = 1'b1;
                launch.id   = tid_r;
                launch.prio = rprio_r;
                res_status  = ST_QUEUED;
                if (total_r == '0) begin
                  total_nxt = total_r + 1'b1;
                end else begin
                  walk_nxt  = total_r;
                  state_nxt = S_INSERT;
                end
              end
            end
            OP_RELEASE: begin
              if (total_r != '0) begin
                cctrl.pop  = 1'b1;
                total_nxt  = total_r - 1'b1;
                res_status = ST_WOKEN;
                res_who    = cell_id[0];
              end else if (count_r < CMAX) begin
                count_nxt  = count_r + 1'b1;
                res_status = ST_RAISED;
              end else begin
                res_status = ST_FULL;
              end
            end
            OP_RESET: begin
              if (total_r != '0) begin
                cctrl.pop  = 1'b1;
                total_nxt  = total_r - 1'b1;
                res_status = ST_RESET_WAKE;
                res_who    = cell_id[0];
                res_last   = 1'b0;
                state_nxt  = S_EXEC;
              end else begin
                count_nxt  = (nc_r > CMAX) ? CMAX : nc_r;
                res_status = ST_RESET_DONE;
              end
            end
            default: begin
              state_nxt = S_IDLE;
            end
          endcase
        end
      end
      S_INSERT: begin
        // The carry lands in the first free cell when walk_r has counted down to one.
        if (walk_r == TW'(1)) begin
          total_nxt = total_r + 1'b1;
          state_nxt = S_IDLE;
        end else begin
          walk_nxt = walk_r - 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control and count registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      count_r <= '0;
      total_r <= '0;
      walk_r  <= '0;
      mode_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
      total_r <= total_nxt;
      walk_r  <= walk_nxt;
      if (cfg_wr_en) begin
        mode_r <= cfg_wr_data;
      end
    end
  end

  // Latched transaction payload.
  always_ff @(posedge clk) begin
    op_r    <= op_nxt;
    tid_r   <= tid_nxt;
    rprio_r <= rprio_nxt;
    nc_r    <= nc_nxt;
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= res_status;
      out_who_r    <= res_who;
      out_count_r  <= count_nxt;
      out_last_r   <= res_last;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {out_count_r, out_who_r};
  assign out_tuser  = out_status_r;
  assign out_tlast  = out_last_r;

endmodule

// File: rtl/csq_cell.sv
`timescale 1ns / 1ps

module csq_cell
  import csq_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  cell_ctrl_t        ctrl,
  input  logic              occ,
  input  carry_t            cin,
  output carry_t            cout,
  input  logic [ID_W-1:0]   nb_id,
  input  logic [PRIO_W-1:0] nb_prio,
  output logic [ID_W-1:0]   id_o,
  output logic [PRIO_W-1:0] prio_o
);

  logic [ID_W-1:0]   id_r, id_nxt;
  logic [PRIO_W-1:0] prio_r, prio_nxt;
  carry_t            cout_r, cout_nxt;

  // A pop shifts every entry one cell toward the head. An arriving carry is
  // absorbed by an empty cell, displaces the entry it must go ahead of, or
  // passes on unchanged.
  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    cout_nxt = '0;
    if (ctrl.pop) begin
      id_nxt   = nb_id;
      prio_nxt = nb_prio;
    end else if (cin.vld) begin
      if (!occ) begin
        id_nxt   = cin.id;
        prio_nxt = cin.prio;
      end else if (cin.disp || (ctrl.mode && (cin.prio < prio_r))) begin
        id_nxt        = cin.id;
        prio_nxt      = cin.prio;
        cout_nxt.vld  = 1'b1;
        cout_nxt.disp = 1'b1;
        cout_nxt.id   = id_r;
        cout_nxt.prio = prio_r;
      end else begin
        cout_nxt = cin;
      end
    end
  end

  // Entry contents hold no reset value.
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  // Carry handed to the next cell.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cout_r <= '0;
    end else begin
      cout_r <= cout_nxt;
    end
  end

  assign cout   = cout_r;
  assign id_o   = id_r;
  assign prio_o = prio_r;

endmodule
